FILE: rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the page span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;
    localparam int MaxSpans   = 64;
    localparam int SmallLists = 128;
    localparam int PageBits   = 24;
    localparam int SlotW      = $clog2(MaxSpans);
    localparam int LenW       = 25;
    localparam int StampW     = 32;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [LenW-1:0]     page_count;
        logic [PageBits-1:0] span_start;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [PageBits-1:0] result_start;
        logic [LenW-1:0]     result_length;
    } res_t;
endpackage

FILE: rtl/page_span_allocator_top.sv
// ----------------------------------------------------------------------------
// page_span_allocator_top
// Page span allocator: allocate, free and add page spans in a 64-slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command word per handshake on the s_ channel: tuser carries the
//   action (0 allocate, 1 free, 2 add region), tdata the page count and span
//   start. Every command yields exactly one result word on the m_ channel:
//   status, result start and result length.
//   A two-entry queue decouples the input handshake from the span engine, so
//   up to two commands are taken while the engine is busy.
//   Timing: each command scans all 64 slots through a registered read port,
//   one slot per cycle, then writes back. The engine takes a new command only
//   after the result word of the last one has been accepted.
//   A stalled m_tready holds the result word and the engine; the queue keeps
//   taking input until it is full.
//   Reset (aresetn low, synchronous) empties the table and the queue and
//   clears the stamp counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_span_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [24:0] page_count, [48:25] span_start
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [23:0] result_start, [48:24] result_length
    output logic [1:0]  m_tuser    // [1:0] status
);
    psa_pkg::cmd_t in_cmd, q_cmd;
    psa_pkg::res_t res;
    logic          q_valid, q_ready;

    assign in_cmd.action     = s_tuser;
    assign in_cmd.page_count = s_tdata[24:0];
    assign in_cmd.span_start = s_tdata[48:25];

    psa_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    psa_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack result word, pad to whole bytes
    assign m_tuser = res.status;
    assign m_tdata = {7'd0, res.result_length, res.result_start};

    logic unused_pad;
    assign unused_pad = ^s_tdata[55:49];
endmodule

FILE: rtl/psa_cmd_queue.sv
// ----------------------------------------------------------------------------
// psa_cmd_queue
// Two-entry command queue between the front end and the span engine.
// ----------------------------------------------------------------------------
module psa_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  psa_pkg::cmd_t  in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output psa_pkg::cmd_t  out_cmd
);
    psa_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: rtl/psa_engine.sv
// ----------------------------------------------------------------------------
// psa_engine
// Span table and scan sequencer: one pass over all slots, then write back.
// ----------------------------------------------------------------------------
module psa_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  psa_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output psa_pkg::res_t  res
);
    localparam int SlotW  = psa_pkg::SlotW;
    localparam int LenW   = psa_pkg::LenW;
    localparam int PB     = psa_pkg::PageBits;
    localparam int StampW = psa_pkg::StampW;
    localparam int CntW   = SlotW + 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_WRITE, S_OUT} state_t;

    // slot memories, one read port each
    logic [PB-1:0]     start_mem [psa_pkg::MaxSpans];
    logic [LenW-1:0]   len_mem   [psa_pkg::MaxSpans];
    logic [StampW-1:0] stamp_mem [psa_pkg::MaxSpans];
    logic [psa_pkg::MaxSpans-1:0] valid_reg, free_reg;

    state_t            state_reg;
    psa_pkg::cmd_t     cmd_reg;
    psa_pkg::res_t     res_reg;
    psa_pkg::res_t     res_next;
    logic              res_valid_reg;
    logic [CntW-1:0]   idx_reg;      // address issued
    logic [SlotW-1:0]  ridx_reg;     // slot whose data is on the read bus
    logic              rvld_reg;
    logic [PB-1:0]     rd_start_reg;
    logic [LenW-1:0]   rd_len_reg;
    logic [StampW-1:0] rd_age_reg;
    logic [StampW-1:0] stamp_reg;

    logic              sb_hit_reg, lb_hit_reg, fb_hit_reg, sp_hit_reg;
    logic [SlotW-1:0]  sb_idx_reg, lb_idx_reg, fb_idx_reg, sp_idx_reg;
    logic [LenW-1:0]   sb_len_reg, lb_len_reg;
    logic [StampW-1:0] sb_age_reg;
    logic [PB-1:0]     sb_start_reg, lb_start_reg;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // scan compare on the registered read data
    logic sl_v, is_small, fits, small_cand, large_cand, free_cand, sp_cand;
    logic small_better, large_better;
    always_comb begin
        sl_v       = valid_reg[ridx_reg];
        is_small   = rd_len_reg < LenW'(psa_pkg::SmallLists);
        fits       = rd_len_reg >= cmd_reg.page_count;
        small_cand = rvld_reg && sl_v && free_reg[ridx_reg] && is_small && fits;
        large_cand = rvld_reg && sl_v && free_reg[ridx_reg] && !is_small && fits;
        free_cand  = rvld_reg && sl_v && !free_reg[ridx_reg]
                     && rd_start_reg == cmd_reg.span_start;
        sp_cand    = rvld_reg && !sl_v;
        small_better = !sb_hit_reg || rd_len_reg < sb_len_reg
                       || (rd_len_reg == sb_len_reg && rd_age_reg < sb_age_reg);
        large_better = !lb_hit_reg || rd_len_reg < lb_len_reg
                       || (rd_len_reg == lb_len_reg && rd_start_reg < lb_start_reg);
    end

    // pick and remainder after the scan
    logic             pick_hit;
    logic [SlotW-1:0] pick_idx;
    logic [LenW-1:0]  pick_len, remain;
    logic [PB-1:0]    pick_start;
    always_comb begin
        pick_hit   = (sb_hit_reg || lb_hit_reg) && cmd_reg.page_count != '0;
        pick_idx   = sb_hit_reg ? sb_idx_reg : lb_idx_reg;
        pick_len   = sb_hit_reg ? sb_len_reg : lb_len_reg;
        pick_start = sb_hit_reg ? sb_start_reg : lb_start_reg;
        remain     = pick_len - cmd_reg.page_count;
    end

    // result word for the command in hand
    always_comb begin
        res_next = '{status: psa_pkg::ST_OK, result_start: '0, result_length: '0};
        case (cmd_reg.action)
            psa_pkg::ACT_ALLOC: begin
                if (!pick_hit) begin
                    res_next.status = psa_pkg::ST_NOFIT;
                end else if (remain != '0 && !sp_hit_reg) begin
                    res_next.status = psa_pkg::ST_FULL;
                end else begin
                    res_next.result_start  = pick_start;
                    res_next.result_length = cmd_reg.page_count;
                end
            end
            psa_pkg::ACT_FREE: begin
                if (!fb_hit_reg) res_next.status = psa_pkg::ST_NOTFOUND;
            end
            psa_pkg::ACT_ADD: begin
                if (cmd_reg.page_count != '0 && !sp_hit_reg) begin
                    res_next.status = psa_pkg::ST_FULL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        // read port
        rd_start_reg <= start_mem[idx_reg[SlotW-1:0]];
        rd_len_reg   <= len_mem[idx_reg[SlotW-1:0]];
        rd_age_reg   <= stamp_reg - stamp_mem[idx_reg[SlotW-1:0]];
        ridx_reg     <= idx_reg[SlotW-1:0];
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            free_reg      <= '0;
            stamp_reg     <= '0;
            res_valid_reg <= 1'b0;
            rvld_reg      <= 1'b0;
            idx_reg       <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg    <= cmd;
                        idx_reg    <= '0;
                        rvld_reg   <= 1'b0;
                        sb_hit_reg <= 1'b0;
                        lb_hit_reg <= 1'b0;
                        fb_hit_reg <= 1'b0;
                        sp_hit_reg <= 1'b0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ: begin
                    // issue next address, consume previous read
                    if (idx_reg != CntW'(psa_pkg::MaxSpans)) begin
                        idx_reg  <= idx_reg + 1'b1;
                        rvld_reg <= 1'b1;
                    end else begin
                        rvld_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    if (small_cand && small_better) begin
                        sb_hit_reg <= 1'b1; sb_idx_reg <= ridx_reg;
                        sb_len_reg <= rd_len_reg; sb_age_reg <= rd_age_reg;
                        sb_start_reg <= rd_start_reg;
                    end
                    if (large_cand && large_better) begin
                        lb_hit_reg <= 1'b1; lb_idx_reg <= ridx_reg;
                        lb_len_reg <= rd_len_reg; lb_start_reg <= rd_start_reg;
                    end
                    if (free_cand && !fb_hit_reg) begin
                        fb_hit_reg <= 1'b1; fb_idx_reg <= ridx_reg;
                    end
                    if (sp_cand && !sp_hit_reg) begin
                        sp_hit_reg <= 1'b1; sp_idx_reg <= ridx_reg;
                    end
                end
                S_SCAN: begin
                    // settle cycle: the last slot was folded in on the final read cycle
                    if (small_cand && small_better) begin
                        sb_hit_reg <= 1'b1; sb_idx_reg <= ridx_reg;
                        sb_len_reg <= rd_len_reg; sb_age_reg <= rd_age_reg;
                        sb_start_reg <= rd_start_reg;
                    end
                    if (large_cand && large_better) begin
                        lb_hit_reg <= 1'b1; lb_idx_reg <= ridx_reg;
                        lb_len_reg <= rd_len_reg; lb_start_reg <= rd_start_reg;
                    end
                    if (free_cand && !fb_hit_reg) begin
                        fb_hit_reg <= 1'b1; fb_idx_reg <= ridx_reg;
                    end
                    if (sp_cand && !sp_hit_reg) begin
                        sp_hit_reg <= 1'b1; sp_idx_reg <= ridx_reg;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    res_reg <= res_next;
                    case (cmd_reg.action)
                        psa_pkg::ACT_ALLOC: begin
                            if (pick_hit && (remain == '0 || sp_hit_reg)) begin
                                free_reg[pick_idx] <= 1'b0;
                                if (remain != '0) begin
                                    len_mem[pick_idx]    <= cmd_reg.page_count;
                                    valid_reg[sp_idx_reg] <= 1'b1;
                                    free_reg[sp_idx_reg]  <= 1'b1;
                                    start_mem[sp_idx_reg] <= pick_start
                                        + cmd_reg.page_count[PB-1:0];
                                    len_mem[sp_idx_reg]   <= remain;
                                    stamp_mem[sp_idx_reg] <= stamp_reg;
                                    stamp_reg <= stamp_reg + 1'b1;
                                end
                            end
                        end
                        psa_pkg::ACT_FREE: begin
                            if (fb_hit_reg) begin
                                free_reg[fb_idx_reg]  <= 1'b1;
                                stamp_mem[fb_idx_reg] <= stamp_reg;
                                stamp_reg <= stamp_reg + 1'b1;
                            end
                        end
                        psa_pkg::ACT_ADD: begin
                            if (cmd_reg.page_count != '0 && sp_hit_reg) begin
                                valid_reg[sp_idx_reg] <= 1'b1;
                                free_reg[sp_idx_reg]  <= 1'b1;
                                start_mem[sp_idx_reg] <= cmd_reg.span_start;
                                len_mem[sp_idx_reg]   <= cmd_reg.page_count;
                                stamp_mem[sp_idx_reg] <= stamp_reg;
                                stamp_reg <= stamp_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
